>>> rtl/fpa_pkg.sv
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int W         = 32;
    localparam int NB        = W + FRAC_BITS;

    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_LT       = 4'd4,
        CMD_GT       = 4'd5,
        CMD_LE       = 4'd6,
        CMD_GE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_MIN      = 4'd10,
        CMD_MAX      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_TO_INT   = 4'd14,
        CMD_FROM_INT = 4'd15
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_MUL   = 2'd1,
        KIND_DIV   = 2'd2
    } kind_t;

    typedef struct packed {
        logic            valid;
        kind_t           kind;
        logic            neg;
        logic [W-1:0]    value;
        logic            flag;
        status_t         status;
        logic [2*W-1:0]  prod;
        logic [W-1:0]    dvs;
        logic [W-1:0]    rem;
        logic [NB-1:0]   nq;
    } item_t;

    function automatic logic ovf33(input logic [W:0] v);
        return v[W] != v[W-1];
    endfunction

    function automatic logic [W-1:0] sat33(input logic [W:0] v);
        if (v[W] != v[W-1])
        begin
            return v[W] ? WORD_MIN : WORD_MAX;
        end
        return v[W-1:0];
    endfunction

endpackage

>>> rtl/fixed_point_alu.sv
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   cmd, operand_a, operand_b
// result    out        out_valid/out_stall result_value, compare_flag, status
//
// One request is taken every cycle while in_stall is low.
// The pipeline depth is set by the divider chain, one quotient bit per cell, which every
// operation passes through so that results stay in order.
// Reset clears all valid bits; no clearing pass is needed.
// A stalled output parks one extra result in a skid register, after which in_stall rises.
module fixed_point_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          cmd,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  result_value,
    output logic                compare_flag,
    output logic [1:0]          status
);
    import fpa_pkg::*;

    item_t chain [NB+1];
    logic  en;

    assign in_stall = !en;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_take   (in_valid),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .item_out  (chain[0])
    );

    for (genvar i = 0; i < NB; i++)
    begin : g_cell
        fpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    fpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_in      (chain[NB]),
        .en           (en),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .compare_flag (compare_flag),
        .status       (status)
    );

endmodule

>>> rtl/fpa_front.sv
module fpa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_take,
    input  logic [3:0]        cmd,
    input  logic [31:0]       operand_a,
    input  logic [31:0]       operand_b,
    output fpa_pkg::item_t    item_out
);
    import fpa_pkg::*;

    item_t        item_reg;
    item_t        item_next;
    logic [W:0]   sa, sb, sum, diff, incv, decv;
    logic [W-1:0] mag_a, mag_b, bias;
    logic signed [NB-1:0] fi;
    logic         lt, eq, ovf_fi;

    always_comb
    begin
        sa    = {operand_a[W-1], operand_a};
        sb    = {operand_b[W-1], operand_b};
        sum   = sa + sb;
        diff  = sa - sb;
        incv  = sa + (W+1)'(1);
        decv  = sa - (W+1)'(1);
        mag_a = operand_a[W-1] ? (W)'(-operand_a) : operand_a;
        mag_b = operand_b[W-1] ? (W)'(-operand_b) : operand_b;
        lt    = $signed(operand_a) < $signed(operand_b);
        eq    = operand_a == operand_b;
        bias  = operand_a[W-1] ? W'((1 << FRAC_BITS) - 1) : '0;
        fi    = $signed({{FRAC_BITS{operand_a[W-1]}}, operand_a}) <<< FRAC_BITS;
        // The scaled integer fits only when the bits above the word all copy its sign.
        ovf_fi = !((&fi[NB-1:W-1]) || !(|fi[NB-1:W-1]));
    end

    always_comb
    begin
        item_next        = '0;
        item_next.valid  = in_take;
        item_next.kind   = KIND_PLAIN;
        item_next.status = ST_OK;
        item_next.neg    = operand_a[W-1] ^ operand_b[W-1];
        item_next.prod   = mag_a * mag_b;
        item_next.dvs    = mag_b;
        item_next.rem    = '0;
        item_next.nq     = {mag_a, {FRAC_BITS{1'b0}}};
        case (cmd_t'(cmd))
            CMD_ADD:
            begin
                item_next.value  = sat33(sum);
                item_next.status = ovf33(sum) ? ST_OVERFLOW : ST_OK;
            end
            CMD_SUB:
            begin
                item_next.value  = sat33(diff);
                item_next.status = ovf33(diff) ? ST_OVERFLOW : ST_OK;
            end
            CMD_MUL:
            begin
                item_next.kind = KIND_MUL;
            end
            CMD_DIV:
            begin
                if (operand_b == '0)
                begin
                    item_next.status = ST_DIV_ZERO;
                    item_next.value  = operand_a[W-1] ? WORD_MIN :
                                       (operand_a == '0 ? '0 : WORD_MAX);
                end
                else
                begin
                    item_next.kind = KIND_DIV;
                end
            end
            CMD_LT:  item_next.flag = lt;
            CMD_GT:  item_next.flag = !lt && !eq;
            CMD_LE:  item_next.flag = lt || eq;
            CMD_GE:  item_next.flag = !lt;
            CMD_EQ:  item_next.flag = eq;
            CMD_NE:  item_next.flag = !eq;
            CMD_MIN: item_next.value = lt ? operand_a : operand_b;
            CMD_MAX: item_next.value = (!lt && !eq) ? operand_a : operand_b;
            CMD_INC:
            begin
                item_next.value  = sat33(incv);
                item_next.status = ovf33(incv) ? ST_OVERFLOW : ST_OK;
            end
            CMD_DEC:
            begin
                item_next.value  = sat33(decv);
                item_next.status = ovf33(decv) ? ST_OVERFLOW : ST_OK;
            end
            CMD_TO_INT:
            begin
                item_next.value = W'($signed(operand_a + bias) >>> FRAC_BITS);
            end
            CMD_FROM_INT:
            begin
                item_next.value  = ovf_fi ? (operand_a[W-1] ? WORD_MIN : WORD_MAX)
                                          : fi[W-1:0];
                item_next.status = ovf_fi ? ST_OVERFLOW : ST_OK;
            end
            default: item_next.value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

>>> rtl/fpa_cell.sv
module fpa_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  fpa_pkg::item_t    item_in,
    output fpa_pkg::item_t    item_out
);
    import fpa_pkg::*;

    item_t      item_reg;
    item_t      item_next;
    logic [W:0] trial;
    logic       fits;

    // One restoring division step: bring down the next numerator bit and
    // shift the resulting quotient bit in behind it.
    always_comb
    begin
        trial     = {item_in.rem, item_in.nq[NB-1]};
        fits      = trial >= {1'b0, item_in.dvs};
        item_next = item_in;
        item_next.rem = fits ? W'(trial - {1'b0, item_in.dvs}) : trial[W-1:0];
        item_next.nq  = {item_in.nq[NB-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

>>> rtl/fpa_back.sv
module fpa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  fpa_pkg::item_t    item_in,
    output logic              en,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       result_value,
    output logic              compare_flag,
    output logic [1:0]        status
);
    import fpa_pkg::*;

    logic [2*W-1:0] qm, qd, q;
    logic           up;
    logic [W-1:0]   fin_value;
    status_t        fin_status;
    logic           fresh, take;

    logic           out_valid_reg, out_valid_next;
    logic [W-1:0]   value_reg, value_next;
    logic           flag_reg, flag_next;
    status_t        status_reg, status_next;
    logic           skid_full_reg, skid_full_next;
    logic [W-1:0]   skid_value_reg, skid_value_next;
    logic           skid_flag_reg, skid_flag_next;
    status_t        skid_status_reg, skid_status_next;

    // For products and quotients, round half away from zero on the magnitude, then apply the sign and clamp.
    always_comb
    begin
        qm = (item_in.prod + (2*W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        up = {item_in.rem, 1'b0} >= {1'b0, item_in.dvs};
        qd = (2*W)'(item_in.nq) + (2*W)'(up);
        q  = (item_in.kind == KIND_MUL) ? qm : qd;
        fin_value  = item_in.value;
        fin_status = item_in.status;
        if (item_in.kind != KIND_PLAIN)
        begin
            fin_status = ST_OK;
            if (item_in.neg)
            begin
                if (q > (2*W)'(WORD_MIN))
                begin
                    fin_value  = WORD_MIN;
                    fin_status = ST_OVERFLOW;
                end
                else
                begin
                    fin_value = W'(-q);
                end
            end
            else
            begin
                if (q > (2*W)'(WORD_MAX))
                begin
                    fin_value  = WORD_MAX;
                    fin_status = ST_OVERFLOW;
                end
                else
                begin
                    fin_value = q[W-1:0];
                end
            end
        end
    end

    assign en    = !skid_full_reg;
    assign fresh = item_in.valid && en;
    assign take  = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        value_next       = value_reg;
        flag_next        = flag_reg;
        status_next      = status_reg;
        skid_full_next   = skid_full_reg;
        skid_value_next  = skid_value_reg;
        skid_flag_next   = skid_flag_reg;
        skid_status_next = skid_status_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_full_reg)
            begin
                out_valid_next = 1'b1;
                value_next     = skid_value_reg;
                flag_next      = skid_flag_reg;
                status_next    = skid_status_reg;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_valid_next = fresh;
                value_next     = fin_value;
                flag_next      = item_in.flag;
                status_next    = fin_status;
            end
        end
        else if (fresh)
        begin
            skid_full_next   = 1'b1;
            skid_value_next  = fin_value;
            skid_flag_next   = item_in.flag;
            skid_status_next = fin_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg       <= value_next;
        flag_reg        <= flag_next;
        status_reg      <= status_next;
        skid_value_reg  <= skid_value_next;
        skid_flag_reg   <= skid_flag_next;
        skid_status_reg <= skid_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign compare_flag = flag_reg;
    assign status       = status_reg;

endmodule

>>> tb/tb_fixed_point_alu.sv
module tb_fixed_point_alu;
    import fpa_pkg::*;

    typedef struct {
        cmd_t               op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    typedef struct {
        logic signed [31:0] value;
        logic               flag;
        logic [1:0]         st;
    } alu_res_t;

    localparam int          IDLE_LIMIT = 2000;
    localparam longint      SMAX       = 64'sd2147483647;
    localparam longint      SMIN       = -64'sd2147483648;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_value;
    logic               compare_flag;
    logic [1:0]         status;

    alu_req_t req_queue[$];
    alu_res_t result_queue[$];
    int       n_errors;
    int       n_sent;
    int       n_checked;
    int       idle_cycles;
    int       send_gap;
    int       stall_left;
    int       quiet_from;
    logic     req_taken;
    logic     done_filling;

    fixed_point_alu u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .compare_flag (compare_flag),
        .status       (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint clamp_word(input longint v, inout logic [1:0] st);
        if (v > SMAX)
        begin
            st = ST_OVERFLOW;
            return SMAX;
        end
        if (v < SMIN)
        begin
            st = ST_OVERFLOW;
            return SMIN;
        end
        return v;
    endfunction

    function automatic longint apply_sign(input longint unsigned mag, input logic neg,
                                          inout logic [1:0] st);
        if (mag > (64'd1 << 40))
        begin
            st = ST_OVERFLOW;
            return neg ? SMIN : SMAX;
        end
        return clamp_word(neg ? -longint'(mag) : longint'(mag), st);
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic alu_res_t alu_predict(input alu_req_t rq);
        alu_res_t          res;
        longint            a;
        longint            b;
        longint            r;
        longint unsigned   p;
        longint unsigned   n;
        longint unsigned   d;
        logic              neg;
        logic [1:0]        st;
        a   = rq.a;
        b   = rq.b;
        r   = 0;
        st  = ST_OK;
        neg = (a < 0) != (b < 0);
        res.flag = 1'b0;
        case (rq.op)
            CMD_ADD:  r = clamp_word(a + b, st);
            CMD_SUB:  r = clamp_word(a - b, st);
            CMD_MUL:
            begin
                p = magnitude(a) * magnitude(b);
                r = apply_sign((p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS, neg, st);
            end
            CMD_DIV:
            begin
                if (b == 0)
                begin
                    st = ST_DIV_ZERO;
                    r  = a > 0 ? SMAX : (a < 0 ? SMIN : 0);
                end
                else
                begin
                    n = magnitude(a) << FRAC_BITS;
                    d = magnitude(b);
                    r = apply_sign((2 * n + d) / (2 * d), neg, st);
                end
            end
            CMD_LT:   res.flag = a < b;
            CMD_GT:   res.flag = a > b;
            CMD_LE:   res.flag = a <= b;
            CMD_GE:   res.flag = a >= b;
            CMD_EQ:   res.flag = a == b;
            CMD_NE:   res.flag = a != b;
            CMD_MIN:  r = a < b ? a : b;
            CMD_MAX:  r = a > b ? a : b;
            CMD_INC:  r = clamp_word(a + 1, st);
            CMD_DEC:  r = clamp_word(a - 1, st);
            CMD_TO_INT: r = a / (longint'(1) << FRAC_BITS);
            default:  r = clamp_word(a * (longint'(1) << FRAC_BITS), st);
        endcase
        res.value = r[31:0];
        res.st    = st;
        return res;
    endfunction

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return $urandom_range(0, 2) - 1;
            3:       return $signed($urandom_range(0, 4095)) - 2048;
            4:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input cmd_t op, input logic signed [31:0] a,
                           input logic signed [31:0] b);
        alu_req_t rq;
        rq.op = op;
        rq.a  = a;
        rq.b  = b;
        req_queue.push_back(rq);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    // Requests are accepted and results checked on the rising edge.
    always @(posedge clk)
    begin
        alu_req_t rq;
        alu_res_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                rq.op = cmd_t'(cmd);
                rq.a  = operand_a;
                rq.b  = operand_b;
                result_queue.push_back(alu_predict(rq));
                req_taken = 1'b1;
                n_sent++;
            end
            if (out_valid && !out_stall)
            begin
                if (result_queue.size() == 0)
                begin
                    report_mismatch("unexpected result", result_value, 0);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (result_value !== want.value)
                        report_mismatch("result_value", result_value, want.value);
                    if (compare_flag !== want.flag)
                        report_mismatch("compare_flag", compare_flag, want.flag);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    n_checked++;
                end
            end
            if (req_taken || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Inputs change on the falling edge.
    always @(negedge clk)
    begin
        logic quiet;
        alu_req_t rq;
        quiet = done_filling && (req_queue.size() < quiet_from);
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_queue.size() > 0)
                begin
                    rq = req_queue.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= rq.op;
                    operand_a <= rq.a;
                    operand_b <= rq.b;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 8);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        cmd          = CMD_ADD;
        operand_a    = '0;
        operand_b    = '0;
        n_errors     = 0;
        n_sent       = 0;
        n_checked    = 0;
        idle_cycles  = 0;
        send_gap     = 0;
        stall_left   = 0;
        quiet_from   = 300;
        req_taken    = 1'b0;
        done_filling = 1'b0;
        rst_n        = 1'b0;

        // Directed cases for every operation: saturation, rounding, division by zero and range edges.
        add_req(CMD_ADD, WORD_MAX, 1);
        add_req(CMD_SUB, WORD_MIN, 1);
        add_req(CMD_MUL, WORD_MAX, WORD_MAX);
        add_req(CMD_MUL, WORD_MIN, WORD_MIN);
        add_req(CMD_MUL, 1, 128);
        add_req(CMD_MUL, -1, 128);
        add_req(CMD_DIV, 1000, 0);
        add_req(CMD_DIV, -1000, 0);
        add_req(CMD_DIV, 0, 0);
        add_req(CMD_DIV, 768, -512);
        add_req(CMD_DIV, WORD_MIN, 1);
        add_req(CMD_LT, WORD_MIN, WORD_MAX);
        add_req(CMD_GT, WORD_MIN, WORD_MAX);
        add_req(CMD_LE, 5, 5);
        add_req(CMD_GE, -5, 5);
        add_req(CMD_EQ, WORD_MIN, WORD_MIN);
        add_req(CMD_NE, WORD_MAX, WORD_MAX);
        add_req(CMD_MIN, WORD_MIN, WORD_MAX);
        add_req(CMD_MAX, WORD_MIN, WORD_MAX);
        add_req(CMD_INC, WORD_MAX, 0);
        add_req(CMD_DEC, WORD_MIN, -1);
        add_req(CMD_TO_INT, -1, 0);
        add_req(CMD_TO_INT, WORD_MIN, 0);
        add_req(CMD_FROM_INT, WORD_MAX, 0);
        add_req(CMD_FROM_INT, -5, 0);
        for (int i = 0; i < 2000; i++)
            add_req(cmd_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
        done_filling = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_queue.size() > 0 || in_valid || result_queue.size() > 0)
            @(posedge clk);
        repeat (32 + FRAC_BITS + 20) @(posedge clk);

        $display("sent %0d requests over all 16 operations, checked %0d results",
                 n_sent, n_checked);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0 && result_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
